@@ rtl/hlkf_pkg.sv @@
// Shared constants, payload types and the keyword table of the header line keyword filter.
package hlkf_pkg;

	localparam int unsigned CHUNK_BYTES  = 4095;
	localparam int unsigned WINDOW_BYTES = 26;
	localparam int unsigned HIST_BYTES   = WINDOW_BYTES - 1;
	localparam int unsigned KEY_BITS     = 8 * WINDOW_BYTES;
	localparam int unsigned COUNT_W      = $clog2(CHUNK_BYTES + 1);
	localparam int unsigned LEN_W        = 12;
	localparam int unsigned KW_COUNT     = 37;
	localparam int unsigned PREFIX_LEN   = 4;

	localparam logic [7:0] CHAR_NL   = 8'h0a;
	localparam logic [7:0] CHAR_NULL = 8'h00;

	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [HIST_BYTES-1:0][7:0] window_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       stream_done;
	} in_word_t;

	typedef struct packed {
		logic             keep_line;
		logic [LEN_W-1:0] chunk_length;
	} out_word_t;

	// Line prefix that drops a chunk; byte 3 is the first character.
	localparam logic [PREFIX_LEN-1:0][7:0] PREFIX_WORD = "From";

	// Keywords, right aligned and zero padded: byte 0 is the last character.
	localparam logic [KEY_BITS-1:0] KEYWORDS [KW_COUNT] = '{
		"From:", "Date:", "Subject:", "SUBJECT:", "To:", "Re:", "Status:",
		"MIME-Version:", "MIME-version:", "Content-Type:", "Return-Path:",
		"Received:", "In-Reply-To:", "Message-ID:", "http:", "www",
		"Newsgroups:", "Content-Transfer-Encoding:", "Content-transfer-encoding:",
		"Appearently-To:", "Message-Id:", "X-Sender:", "X-Mailer:",
		"Mime-Version:", "CC:", "Cc:", "cc:", "X-Sun-Charset:", "Sender:",
		"Orgnaization:", "References:", "X-Loop:", "In-reply-to", "X-UIDL:",
		"X-MSMail-Priority", "X-Priority",
		KEY_BITS'(80'h74656c65706f7274616c) // site name, given in hex
	};

endpackage

@@ rtl/hlkf_in_if.sv @@
// Input word channel of the header line keyword filter.
interface hlkf_in_if;
	import hlkf_pkg::*;

	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/hlkf_out_if.sv @@
// Result word channel of the header line keyword filter.
interface hlkf_out_if;
	import hlkf_pkg::*;

	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/hlkf_match.sv @@
// Parallel keyword compare of the newest byte against the history window.
module hlkf_match (
	input  logic [7:0]       cur_byte,
	input  hlkf_pkg::window_t history,
	input  hlkf_pkg::count_t  count,
	output logic             hit
);
	import hlkf_pkg::*;

	logic [KW_COUNT-1:0] kw_ok;

	always_comb begin
		logic [7:0] key_byte;
		logic [7:0] win_byte;
		for (int unsigned w = 0; w < KW_COUNT; w++) begin
			kw_ok[w] = 1'b1;
			for (int unsigned k = 0; k < WINDOW_BYTES; k++) begin
				key_byte = KEYWORDS[w][8*k +: 8];
				win_byte = (k == 0) ? cur_byte : history[(k == 0) ? 0 : k - 1];
				// key bytes are never zero; a zero marks padding past its start
				if (key_byte != CHAR_NULL) begin
					if (COUNT_W'(k) >= count || win_byte != key_byte)
						kw_ok[w] = 1'b0;
				end
			end
		end
		hit = |kw_ok;
	end
endmodule

@@ rtl/header_line_keyword_filter.sv @@
// Top level of the header line keyword filter: chunking, prefix check and result register.
//
// Splits a byte stream into chunks and returns one word per chunk: keep_line is 0
// when the chunk starts with "From" or holds one of the fixed header keywords
// (case sensitive, all bytes within the chunk), and chunk_length counts its bytes
// with the newline. A chunk closes on a newline, at CHUNK_BYTES bytes, or on a word
// with stream_done set while bytes are open; stream_done on an empty chunk yields
// nothing. A zero byte removes itself and the rest of its chunk from matching.
// Each accepted word is registered, then checked combinationally against all
// keywords at once over a history of the last 25 bytes; the verdict lands in an
// output register. One input word per clock is taken sustained, and a word is
// still taken while a finished verdict waits on the output, unless the registered
// word closes another chunk; then input stalls until the waiting verdict is read.
module header_line_keyword_filter (
	input  logic clk,
	input  logic arst_n,
	hlkf_in_if.sink    text,
	hlkf_out_if.source verdict
);
	import hlkf_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       done_s1;

	// chunk state
	window_t recent_q;
	logic    hit_q;
	count_t  count_q;
	logic    prefix_q;
	logic    null_q;

	// result register
	logic             res_valid_q;
	logic             keep_q;
	logic [LEN_W-1:0] len_q;

	count_t count_next;
	logic   null_next;
	logic   in_prefix;
	logic   prefix_fail;
	logic   prefix_hit;
	logic   kw_hit;
	logic   hit_next;
	logic   emits;
	logic   res_free;
	logic   fire;

	assign count_next = count_q + COUNT_W'(1);
	assign null_next  = null_q | (byte_s1 == CHAR_NULL);
	assign in_prefix  = count_q < COUNT_W'(PREFIX_LEN);

	// prefix check runs on the first four bytes only
	assign prefix_fail = in_prefix &&
		(null_next || byte_s1 != PREFIX_WORD[2'd3 - count_q[1:0]]);
	assign prefix_hit  = in_prefix && count_q[1:0] == 2'd3 && !prefix_fail && prefix_q;

	hlkf_match u_match (
		.cur_byte (byte_s1),
		.history  (recent_q),
		.count    (count_next),
		.hit      (kw_hit)
	);

	assign hit_next = hit_q | prefix_hit | (kw_hit & ~null_next);

	// a done word closes only a non-empty chunk
	assign emits = done_s1 ? (count_q != '0)
	                       : (byte_s1 == CHAR_NL || count_next >= COUNT_W'(CHUNK_BYTES));

	assign res_free   = !res_valid_q || verdict.ready;
	assign fire       = valid_s1 && (!emits || res_free);
	assign text.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.data.text_byte;
			done_s1 <= text.data.stream_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			hit_q    <= 1'b0;
			count_q  <= '0;
			prefix_q <= 1'b1;
			null_q   <= 1'b0;
		end else if (fire) begin
			if (!done_s1) begin
				recent_q <= {recent_q[HIST_BYTES-2:0], byte_s1};
			end
			if (emits) begin
				hit_q    <= 1'b0;
				count_q  <= '0;
				prefix_q <= 1'b1;
				null_q   <= 1'b0;
			end else if (!done_s1) begin
				hit_q    <= hit_next;
				count_q  <= count_next;
				prefix_q <= prefix_q & ~prefix_fail;
				null_q   <= null_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && emits) begin
			res_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emits) begin
			keep_q <= done_s1 ? ~hit_q : ~hit_next;
			len_q  <= done_s1 ? LEN_W'(count_q) : LEN_W'(count_next);
		end
	end

	assign verdict.valid             = res_valid_q;
	assign verdict.data.keep_line    = keep_q;
	assign verdict.data.chunk_length = len_q;

	// open chunk never reaches the chunk limit
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < COUNT_W'(CHUNK_BYTES))
		else $error("chunk byte count out of range");

	// a reported chunk always holds at least one byte
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> len_q != '0)
		else $error("empty chunk reported");

	// closing a chunk restarts the count
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emits) |=> count_q == '0)
		else $error("chunk state not cleared on close");

	// an empty chunk carries no leftover match state
	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> (prefix_q && !hit_q && !null_q))
		else $error("stale state in empty chunk");
endmodule

@@ dv/hlkf_verdict_checker.sv @@
// Watches both channels of the header line keyword filter, predicts each chunk verdict and compares.
module hlkf_verdict_checker (
	input  logic        clk,
	input  logic        arst_n,
	hlkf_in_if          text,
	hlkf_out_if         verdict,
	output int unsigned fail_count,
	output int unsigned due_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import hlkf_pkg::*;

	localparam int unsigned KEY_COUNT = 37;
	localparam int unsigned MAX_PRINTS = 40;

	// right aligned, zero padded: byte 0 holds the last character
	localparam logic [8*WINDOW_BYTES-1:0] HEADER_KEYS [KEY_COUNT] = '{
		"From:", "Date:", "Subject:", "SUBJECT:", "To:", "Re:", "Status:",
		"MIME-Version:", "MIME-version:", "Content-Type:", "Return-Path:",
		"Received:", "In-Reply-To:", "Message-ID:", "http:", "www",
		"Newsgroups:", "Content-Transfer-Encoding:", "Content-transfer-encoding:",
		"Appearently-To:", "Message-Id:", "X-Sender:", "X-Mailer:",
		"Mime-Version:", "CC:", "Cc:", "cc:", "X-Sun-Charset:", "Sender:",
		"Orgnaization:", "References:", "X-Loop:", "In-reply-to", "X-UIDL:",
		"X-MSMail-Priority", "X-Priority",
		80'h74656c65706f7274616c // site name, kept in hex
	};

	localparam logic [7:0] LEAD_WORD [4] = '{"F", "r", "o", "m"};

	logic [7:0]  past_bytes [WINDOW_BYTES-1];   // index 0 newest
	int unsigned open_bytes;
	bit          dropped;
	bit          lead_ok;
	bit          nul_seen;
	out_word_t   verdicts_due [$];

	initial fail_count = 0;

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= MAX_PRINTS)
			$display("[%0t] verdict check: %s", $realtime, msg);
	endtask

	function automatic bit key_ends_here(input int idx, input logic [7:0] b);
		logic [8*WINDOW_BYTES-1:0] key;
		int len;
		key = HEADER_KEYS[idx];
		len = 0;
		while (len < WINDOW_BYTES && key[8*len +: 8] != 8'h00)
			len++;
		if (len == 0 || len > open_bytes)
			return 1'b0;
		if (key[7:0] != b)
			return 1'b0;
		for (int k = 1; k < len; k++)
			if (key[8*k +: 8] != past_bytes[k-1])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic close_chunk();
		out_word_t v;
		v.keep_line    = !dropped;
		v.chunk_length = LEN_W'(open_bytes);
		verdicts_due.push_back(v);
		open_bytes = 0;
		dropped    = 1'b0;
		lead_ok    = 1'b1;
		nul_seen   = 1'b0;
	endtask

	task automatic take_word(input in_word_t w);
		logic [7:0] b;
		int unsigned pos;
		b = w.text_byte;
		if (w.stream_done) begin
			if (open_bytes != 0)
				close_chunk();
			return;
		end
		pos = open_bytes;
		open_bytes++;
		if (b == CHAR_NULL)
			nul_seen = 1'b1;
		if (pos < 4) begin
			if (nul_seen || b != LEAD_WORD[pos])
				lead_ok = 1'b0;
			else if (pos == 3 && lead_ok)
				dropped = 1'b1;
		end
		if (!nul_seen)
			for (int k = 0; k < KEY_COUNT; k++)
				if (key_ends_here(k, b))
					dropped = 1'b1;
		for (int k = WINDOW_BYTES - 2; k > 0; k--)
			past_bytes[k] = past_bytes[k-1];
		past_bytes[0] = b;
		if (b == CHAR_NL || open_bytes >= CHUNK_BYTES)
			close_chunk();
	endtask

	task automatic check_result(input out_word_t got);
		out_word_t want;
		if (verdicts_due.size() == 0) begin
			report_mismatch($sformatf("unexpected result keep=%0d len=%0d",
				got.keep_line, got.chunk_length));
			return;
		end
		want = verdicts_due.pop_front();
		if (got.keep_line !== want.keep_line)
			report_mismatch($sformatf("keep_line %0b, want %0b (len %0d)",
				got.keep_line, want.keep_line, want.chunk_length));
		if (got.chunk_length !== want.chunk_length)
			report_mismatch($sformatf("chunk_length %0d, want %0d",
				got.chunk_length, want.chunk_length));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (past_bytes[k])
				past_bytes[k] = 8'h00;
			open_bytes = 0;
			dropped    = 1'b0;
			lead_ok    = 1'b1;
			nul_seen   = 1'b0;
			verdicts_due.delete();
		end else begin
			if (text.valid === 1'b1 && text.ready === 1'b1)
				take_word(text.data);
			if (verdict.valid === 1'b1 && verdict.ready === 1'b1)
				check_result(verdict.data);
		end
		due_count = verdicts_due.size();
	end

endmodule

@@ dv/header_line_keyword_filter_tb.sv @@
// Testbench top of the header line keyword filter: clock, reset, text stimulus and verdict.
module header_line_keyword_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hlkf_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 500_000;
	localparam int unsigned DRAIN_CYCLES = 16;       // output register plus margin
	localparam int unsigned RANDOM_WORDS = 1000;

	// receiver back-pressure styles
	typedef enum int unsigned {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned fail_count;
	int unsigned due_count;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned random_words = 0;
	bit          counting = 1'b0;   // random part running
	bit          held_off = 1'b0;   // mid-run hold-off done
	rx_mode_e    rx_mode = RX_FREE;
	int unsigned rx_left = 0;

	hlkf_in_if  text_ch ();
	hlkf_out_if verdict_ch ();

	header_line_keyword_filter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text_ch),
		.verdict (verdict_ch)
	);

	hlkf_verdict_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text_ch),
		.verdict    (verdict_ch),
		.fail_count (fail_count),
		.due_count  (due_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: switches between back-pressure styles after stretches of random length.
	// Free-running stretches keep the path busy, sparse mode keeps verdicts waiting.
	initial begin
		verdict_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_left == 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 300);
			end
			rx_left--;
			case (rx_mode)
				RX_FREE:     verdict_ch.ready <= 1'b1;
				RX_COIN:     verdict_ch.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE:   verdict_ch.ready <= ($urandom_range(0, 7) == 0);
				RX_PERIODIC: verdict_ch.ready <= (rx_left % 5 != 0);
				default:     verdict_ch.ready <= 1'b1;
			endcase
		end
	end

	// Sends one word. Entered and left right after a falling edge. Bursts of
	// random length run back to back; between bursts valid drops for a random gap.
	task automatic send_word(input in_word_t w);
		if (burst_left == 0) begin
			text_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
				: $urandom_range(1, 24);
		end
		text_ch.valid <= 1'b1;
		text_ch.data  <= w;
		@(posedge clk);
		while (text_ch.ready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
		if (counting)
			random_words++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		in_word_t w;
		w.text_byte   = b;
		w.stream_done = 1'b0;
		send_word(w);
	endtask

	// end of stream; the byte lane carries junk that must be ignored
	task automatic send_done();
		in_word_t w;
		w.text_byte   = 8'($urandom_range(0, 255));
		w.stream_done = 1'b1;
		send_word(w);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Sends a header keyword, optionally with bit 5 of one character flipped (a case
	// flip for a letter) so that it becomes a near miss (or, now and then, another keyword).
	task automatic send_key(input int idx, input bit spoil);
		logic [8*WINDOW_BYTES-1:0] key;
		int len;
		int bad;
		logic [7:0] c;
		key = KEYWORDS[idx];
		len = 0;
		while (len < WINDOW_BYTES && key[8*len +: 8] != 8'h00)
			len++;
		bad = spoil ? $urandom_range(0, len - 1) : -1;
		for (int j = len - 1; j >= 0; j--) begin
			c = key[8*j +: 8];
			if (len - 1 - j == bad)
				c = c ^ 8'h20;
			send_byte(c);
		end
	endtask

	task automatic send_filler(input int unsigned n);
		repeat (n) send_byte(8'($urandom_range(32, 126)));
	endtask

	// Random line: mostly well-formed header-like text, with keywords, the
	// From prefix, near misses, zero bytes and odd endings mixed in.
	task automatic send_line();
		int unsigned pick;
		if ($urandom_range(0, 9) == 0) begin
			// raw noise, any byte value including newlines and zeros
			repeat ($urandom_range(1, 40)) send_byte(8'($urandom_range(0, 255)));
			return;
		end
		pick = $urandom_range(0, 7);
		if (pick == 0)
			send_text("From");
		else if (pick == 1)
			send_text("Frm");
		else if (pick == 2)
			send_text("from");
		send_filler($urandom_range(0, 8));
		if ($urandom_range(0, 2) != 0)
			send_key($urandom_range(0, KW_COUNT - 1), $urandom_range(0, 3) == 0);
		if ($urandom_range(0, 9) == 0)
			send_byte(CHAR_NULL);
		send_filler($urandom_range(0, 6));
		if ($urandom_range(0, 2) == 0)
			send_key($urandom_range(0, KW_COUNT - 1), $urandom_range(0, 3) == 0);
		pick = $urandom_range(0, 9);
		if (pick < 8)
			send_byte(CHAR_NL);
		else if (pick == 8)
			send_done();
		else begin
			// double end: the second closes nothing
			send_done();
			send_done();
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		text_ch.valid      = 1'b0;
		text_ch.data       = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed chunks ---
		send_text("From here\n");                  // prefix drop
		send_text("Fro\n");                        // too short for the prefix
		send_text("From");                         // bare prefix closed by end of stream
		send_done();
		send_done();                               // end on empty chunk: no result
		send_text("Fr");                           // zero byte spoils the prefix
		send_byte(CHAR_NULL);
		send_text("om x\n");
		send_text("ab");                           // zero byte hides a later keyword
		send_byte(CHAR_NULL);
		send_text("Subject: x\n");
		send_text("Subject:");                     // match before the zero stands
		send_byte(CHAR_NULL);
		send_text("z\n");
		send_text("Subj");                         // keyword split by end of stream
		send_done();
		send_text("ect:\n");
		send_text("x Content-Transfer-Encoding: y\n");  // longest keyword, fills window
		send_text("cc:\n");
		send_text("CC\n");
		send_byte(8'hff);
		send_byte(8'h80);
		send_byte(CHAR_NL);
		send_byte(CHAR_NL);                        // one-byte chunk
		send_key(KW_COUNT - 1, 1'b0);              // last table entry
		send_byte(CHAR_NL);

		// Full-size chunk with no newline; its last two bytes start "www"
		// and the third lands in the next chunk, so it must not match.
		repeat (CHUNK_BYTES - 2) begin
			logic [7:0] b;
			b = 8'($urandom_range(1, 255));
			if (b == CHAR_NL)
				b = 8'h20;
			send_byte(b);
		end
		send_text("ww");
		send_text("w\n");

		// --- random part ---
		counting = 1'b1;
		while (random_words < RANDOM_WORDS) begin
			send_line();
			if (random_words >= RANDOM_WORDS / 2 && !held_off) begin
				// hold off once until every verdict is back
				text_ch.valid <= 1'b0;
				do
					@(negedge clk);
				while (due_count != 0);
				held_off = 1'b1;
			end
		end
		send_byte(CHAR_NL);

		text_ch.valid <= 1'b0;
		while (due_count != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && due_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/hlkf_pkg.sv
rtl/hlkf_in_if.sv
rtl/hlkf_out_if.sv
rtl/hlkf_match.sv
rtl/header_line_keyword_filter.sv
dv/hlkf_verdict_checker.sv
dv/header_line_keyword_filter_tb.sv
